// ===== design/sjcv_pkg.sv =====
// Package for the speed jitter CV monitor: beat types, config codes, constants.
// Used by the top level, front, queue, back and checker; no dependencies.
package sjcv_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MEAN  = 1'd1;

    localparam logic [6:0]  MIN_COUNT_RST = 7'd20;
    localparam logic [31:0] MIN_MEAN_RST  = 32'd32768;

    // 1000 ms/s times 16 ticks per ms
    localparam logic [13:0] SPEED_SCALE = 14'd16000;

    typedef struct packed {
        logic signed [31:0] x_pos;
        logic signed [31:0] y_pos;
        logic [15:0]        frame_time;
    } t_sample;

    typedef struct packed {
        logic [23:0] cv_ratio;
        logic        cv_valid;
        logic [6:0]  sample_count;
    } t_result;

    // classified work item handed from front to back
    typedef struct packed {
        logic        take;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [15:0] frame_time;
    } t_work;

    typedef struct packed {
        logic [6:0]  min_count;
        logic [31:0] min_mean;
    } t_cfg;

endpackage

// ===== design/speed_jitter_cv_monitor.sv =====
// Top level of the speed jitter CV monitor: config registers, front, queue, back.
// Depends on sjcv_pkg, sjcv_front, sjcv_fifo and sjcv_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in): one beat per rendered frame,
//   position x, y in Q16.16 and frame time in 1/16 ms. A zero frame time, or the
//   first beat after reset, adds no speed but still yields a result.
//   Output channel (o_out_valid / i_out_ready / o_out): exactly one beat per
//   input beat, in order: std/mean of the windowed speeds (Q8.16, saturating),
//   a valid flag and the number of speeds held.
//   Config port (i_cfg_we / i_cfg_index / i_cfg_data): index 0 min_count,
//   index 1 min_mean; write only while the block is idle.
// Back end:
//   One item at a time in the back end; a new item is taken only once the
//   result of the last one is in the output register. An item's time is set by
//   the shared bit-serial divider (up to four uses per item) and the bit-serial
//   square root (up to two); a beat that adds no speed, or whose ratio is
//   invalid, uses them fewer times.
//   A two-entry queue lets the front accept beats while the back is busy.
// Reset: synchronous, active low; clears window, sums, previous position and
//   restores min_count = 20, min_mean = 0.5. The speed store is not cleared.
// Stall: if the receiver holds i_out_ready low, the result waits in the output
//   register, the back finishes the next item and waits, then the queue fills
//   and o_in_ready drops.
module speed_jitter_cv_monitor #(
    parameter int WINDOW = 120
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  sjcv_pkg::t_sample                   i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output sjcv_pkg::t_result                   o_out,
    input  logic                                i_cfg_we,
    input  logic [sjcv_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sjcv_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    sjcv_pkg::t_cfg  r_cfg;
    sjcv_pkg::t_work q_in_data;
    sjcv_pkg::t_work q_out_data;
    logic            q_push;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;

    // configuration registers, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_count <= sjcv_pkg::MIN_COUNT_RST;
            r_cfg.min_mean  <= sjcv_pkg::MIN_MEAN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sjcv_pkg::CFG_MIN_COUNT: r_cfg.min_count <= i_cfg_data[6:0];
                sjcv_pkg::CFG_MIN_MEAN:  r_cfg.min_mean  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: tracks previous position and classifies each beat
    sjcv_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (q_in_data)
    );

    sjcv_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in_data),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_out_data)
    );

    // back: speed, window update, statistics, output register
    sjcv_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_data    (q_out_data),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// ===== design/sjcv_front.sv =====
// Front end: accepts input beats, forms |dx|, |dy| and decides if a speed is taken.
// Depends on sjcv_pkg.
module sjcv_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  sjcv_pkg::t_sample i_in,
    input  logic            i_q_full,
    output logic            o_q_push,
    output sjcv_pkg::t_work o_q_data
);

    logic signed [31:0] r_prev_x;
    logic signed [31:0] r_prev_y;
    logic               r_has_prev;
    logic [32:0]        dx;
    logic [32:0]        dy;
    logic [32:0]        ndx;
    logic [32:0]        ndy;

    assign o_in_ready = !i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;

    always_comb begin
        dx  = {i_in.x_pos[31], i_in.x_pos} - {r_prev_x[31], r_prev_x};
        dy  = {i_in.y_pos[31], i_in.y_pos} - {r_prev_y[31], r_prev_y};
        ndx = -dx;
        ndy = -dy;
        o_q_data.take       = r_has_prev && (i_in.frame_time != 16'd0);
        o_q_data.ax         = dx[32] ? ndx[31:0] : dx[31:0];
        o_q_data.ay         = dy[32] ? ndy[31:0] : dy[31:0];
        o_q_data.frame_time = i_in.frame_time;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x   <= '0;
            r_prev_y   <= '0;
            r_has_prev <= 1'b0;
        end else if (o_q_push) begin
            r_prev_x   <= i_in.x_pos;
            r_prev_y   <= i_in.y_pos;
            r_has_prev <= 1'b1;
        end
    end

endmodule

// ===== design/sjcv_fifo.sv =====
// Two-entry queue of work items between front and back.
// Depends on sjcv_pkg.
module sjcv_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sjcv_pkg::t_work i_data,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output sjcv_pkg::t_work o_data
);

    sjcv_pkg::t_work r_mem [2];
    logic            r_wr;
    logic            r_rd;
    logic [1:0]      r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

// ===== design/sjcv_div.sv =====
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
// No package dependency.
module sjcv_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);

    logic [31:0] r_rem;
    logic [63:0] r_quo;
    logic [31:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] n_trial;
    logic        n_bit;
    logic [32:0] n_diff;

    assign o_done = r_done;
    assign o_quo  = r_quo;

    always_comb begin
        n_trial = {r_rem, r_quo[63]};
        n_diff  = n_trial - {1'b0, r_den};
        n_bit   = (n_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // one-cycle pulse after the last step
            r_done <= r_busy && (r_cnt == 7'd1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= n_bit ? n_diff[31:0] : n_trial[31:0];
                r_quo <= {r_quo[62:0], n_bit};
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

// ===== design/sjcv_sqrt.sv =====
// Floor square root of a 66-bit value, one root bit per cycle (33 steps).
// No package dependency.
module sjcv_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [65:0] i_op,
    output logic        o_done,
    output logic [32:0] o_root
);

    logic [65:0] r_op;
    logic [36:0] r_rem;
    logic [32:0] r_root;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [36:0] n_rem;
    logic [36:0] n_trial;

    assign o_done = r_done;
    assign o_root = r_root;

    always_comb begin
        n_rem   = {r_rem[34:0], r_op[65:64]};
        n_trial = {2'b00, r_root[32:0], 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // one-cycle pulse after the last step
            r_done <= r_busy && (r_cnt == 6'd1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd33;
                r_op   <= i_op;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_op <= {r_op[63:0], 2'b00};
                if (n_rem >= n_trial) begin
                    r_rem  <= n_rem - n_trial;
                    r_root <= {r_root[31:0], 1'b1};
                end else begin
                    r_rem  <= n_rem;
                    r_root <= {r_root[31:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

// ===== design/sjcv_back.sv =====
// Back end: speed, ring window, running sums, statistics and the output register.
// Depends on sjcv_pkg, sjcv_div and sjcv_sqrt.
module sjcv_back #(
    parameter int WINDOW = 120
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sjcv_pkg::t_cfg    i_cfg,
    input  logic              i_q_valid,
    input  sjcv_pkg::t_work   i_q_data,
    output logic              o_q_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sjcv_pkg::t_result o_out
);

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int WP_W  = $clog2(WINDOW);
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
    localparam int SUM_W = 32 + CNT_W;
    localparam int SQS_W = 48 + CNT_W;

    typedef enum logic [4:0] {
        S_IDLE, S_MUL, S_RAD, S_SQ1, S_SCL, S_DV1, S_SQR, S_OSQ, S_UPD,
        S_STAT, S_DV2, S_DV3, S_M2, S_VAR, S_SQ2, S_RAT, S_DV4, S_OUT
    } t_state;

    t_state            r_state;
    sjcv_pkg::t_work   r_work;
    logic [63:0]       r_sx;
    logic [63:0]       r_sy;
    logic [32:0]       r_dist;
    logic [31:0]       r_speed;
    logic [31:0]       r_old;
    logic [47:0]       r_sq;
    logic [47:0]       r_oldsq;
    logic [SUM_W-1:0]  r_sum;
    logic [SQS_W-1:0]  r_sqs;
    logic [WP_W-1:0]   r_wp;
    logic [CNT_W-1:0]  r_count;
    logic [31:0]       r_mean;
    logic [47:0]       r_msq;
    logic [47:0]       r_m2;
    logic [31:0]       r_sd;
    logic              r_div_start;
    logic [63:0]       r_div_num;
    logic [31:0]       r_div_den;
    logic              r_sq_start;
    logic [65:0]       r_sq_op;
    logic              r_out_valid;
    sjcv_pkg::t_result r_out;
    logic [23:0]       r_ratio;
    logic              r_valid;
    logic [31:0]       speed_ring [WINDOW];

    logic              div_done;
    logic [63:0]       div_quo;
    logic              sq_done;
    logic [32:0]       sq_root;
    logic [47:0]       var_val;
    logic              full;
    logic              stat_ok;
    logic              mean_ok;
    logic              n_div_start;
    logic              n_sq_start;

    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign full        = (r_count == CNT_W'(WINDOW));
    assign var_val     = (r_msq > r_m2) ? (r_msq - r_m2) : 48'd0;
    assign stat_ok     = (r_count != '0) &&
                         (CMP_W'(r_count) >= CMP_W'(i_cfg.min_count));
    assign mean_ok     = (div_quo[31:0] != 32'd0) &&
                         (div_quo[31:0] >= i_cfg.min_mean);

    // start pulses for the shared divider and square root
    assign n_sq_start  = (r_state == S_RAD) || (r_state == S_VAR);
    assign n_div_start = (r_state == S_SCL) || (r_state == S_RAT) ||
                         ((r_state == S_STAT) && stat_ok) ||
                         ((r_state == S_DV2) && div_done && mean_ok);

    sjcv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    sjcv_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sq_start),
        .i_op    (r_sq_op),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // window store: read the oldest entry early, overwrite it at update
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_old <= speed_ring[r_wp];
        end
        if (r_state == S_UPD) begin
            speed_ring[r_wp] <= r_speed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_sqs       <= '0;
            r_wp        <= '0;
            r_count     <= '0;
            r_div_start <= 1'b0;
            r_sq_start  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= n_div_start;
            r_sq_start  <= n_sq_start;
            // S_OUT reloads the output register itself
            if (r_out_valid && i_out_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_work  <= i_q_data;
                        r_state <= i_q_data.take ? S_MUL : S_STAT;
                    end
                end
                S_MUL: begin
                    r_sx    <= 64'(r_work.ax) * 64'(r_work.ax);
                    r_sy    <= 64'(r_work.ay) * 64'(r_work.ay);
                    r_state <= S_RAD;
                end
                S_RAD: begin
                    r_sq_op <= 66'(r_sx) + 66'(r_sy);
                    r_state <= S_SQ1;
                end
                S_SQ1: begin
                    if (sq_done) begin
                        r_dist  <= sq_root;
                        r_state <= S_SCL;
                    end
                end
                S_SCL: begin
                    r_div_num <= 64'(r_dist) * 64'(sjcv_pkg::SPEED_SCALE);
                    r_div_den <= 32'(r_work.frame_time);
                    r_state   <= S_DV1;
                end
                S_DV1: begin
                    if (div_done) begin
                        r_speed <= (div_quo[63:32] != 32'd0) ? 32'hFFFF_FFFF
                                                             : div_quo[31:0];
                        r_state <= S_SQR;
                    end
                end
                S_SQR: begin
                    r_sq    <= 48'((64'(r_speed) * 64'(r_speed)) >> 16);
                    r_state <= S_OSQ;
                end
                S_OSQ: begin
                    r_oldsq <= 48'((64'(r_old) * 64'(r_old)) >> 16);
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (full) begin
                        r_sum <= r_sum - SUM_W'(r_old) + SUM_W'(r_speed);
                        r_sqs <= r_sqs - SQS_W'(r_oldsq) + SQS_W'(r_sq);
                    end else begin
                        r_sum   <= r_sum + SUM_W'(r_speed);
                        r_sqs   <= r_sqs + SQS_W'(r_sq);
                        r_count <= r_count + CNT_W'(1);
                    end
                    r_wp    <= (r_wp == WP_W'(WINDOW - 1)) ? '0 : r_wp + WP_W'(1);
                    r_state <= S_STAT;
                end
                S_STAT: begin
                    if (stat_ok) begin
                        r_div_num <= 64'(r_sum);
                        r_div_den <= 32'(r_count);
                        r_state   <= S_DV2;
                    end else begin
                        r_ratio <= '0;
                        r_valid <= 1'b0;
                        r_state <= S_OUT;
                    end
                end
                S_DV2: begin
                    if (div_done) begin
                        r_mean <= div_quo[31:0];
                        if (mean_ok) begin
                            r_div_num <= 64'(r_sqs);
                            r_div_den <= 32'(r_count);
                            r_state   <= S_DV3;
                        end else begin
                            r_ratio <= '0;
                            r_valid <= 1'b0;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_DV3: begin
                    if (div_done) begin
                        r_msq   <= div_quo[47:0];
                        r_state <= S_M2;
                    end
                end
                S_M2: begin
                    r_m2    <= 48'((64'(r_mean) * 64'(r_mean)) >> 16);
                    r_state <= S_VAR;
                end
                S_VAR: begin
                    r_sq_op <= {2'b00, var_val, 16'd0};
                    r_state <= S_SQ2;
                end
                S_SQ2: begin
                    if (sq_done) begin
                        r_sd    <= sq_root[31:0];
                        r_state <= S_RAT;
                    end
                end
                S_RAT: begin
                    r_div_num <= {16'd0, r_sd, 16'd0};
                    r_div_den <= r_mean;
                    r_state   <= S_DV4;
                end
                S_DV4: begin
                    if (div_done) begin
                        r_ratio <= (div_quo[63:24] != 40'd0) ? 24'hFF_FFFF
                                                             : div_quo[23:0];
                        r_valid <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid        <= 1'b1;
                        r_out.cv_ratio     <= r_ratio;
                        r_out.cv_valid     <= r_valid;
                        r_out.sample_count <= 7'(r_count);
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/sjcv_checker.sv =====
// Port-level checker for the speed jitter CV monitor, bound to the top level.
// Depends on sjcv_pkg and speed_jitter_cv_monitor.
module sjcv_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input sjcv_pkg::t_result o_out
);

    // a pending result beat holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("output beat dropped or changed while stalled");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.cv_valid) |-> (o_out.cv_ratio == 24'd0))
        else $error("invalid ratio not zero");

    a_valid_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.cv_valid) |-> (o_out.sample_count != 7'd0))
        else $error("valid ratio with empty window");

endmodule

bind speed_jitter_cv_monitor sjcv_checker u_sjcv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
